// ===== rtl/ihrc_pkg.sv =====
// ----------------------------------------------------------------------------
// ihrc_pkg
// shared types and constants of the ipv4 header receive check
// ----------------------------------------------------------------------------
package ihrc_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_LOCAL_ADDRESS = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SLOT_ENABLE   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SLOT0_PROTO   = 3'd2;

  localparam logic [2:0] ST_DELIVER       = 3'd0;
  localparam logic [2:0] ST_NOT_ADDRESSED = 3'd1;
  localparam logic [2:0] ST_CHECKSUM_BAD  = 3'd2;
  localparam logic [2:0] ST_OPTIONS       = 3'd3;
  localparam logic [2:0] ST_TTL_ZERO      = 3'd4;
  localparam logic [2:0] ST_UNSUPPORTED   = 3'd5;

  localparam logic [3:0] IHL_NO_OPTIONS = 4'd5;

  localparam logic [4:0] POS_TTL_PROTO = 5'd4;
  localparam logic [4:0] POS_SRC_HI    = 5'd6;
  localparam logic [4:0] POS_SRC_LO    = 5'd7;
  localparam logic [4:0] POS_DST_HI    = 5'd8;
  localparam logic [4:0] POS_DST_LO    = 5'd9;

  typedef struct packed {
    logic [15:0] header_word;
    logic        first_word;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  protocol;
    logic [31:0] source_address;
    logic [1:0]  matched_slot;
  } out_word_t;

  typedef struct packed {
    logic [15:0] sum;
    logic [3:0]  ihl;
    logic [7:0]  ttl;
    logic [7:0]  protocol;
    logic [31:0] src;
    logic [31:0] dst;
  } hdr_rec_t;

endpackage

// ===== rtl/ihrc_fifo.sv =====
// ----------------------------------------------------------------------------
// ihrc_fifo
// small register queue with push/full and pop/empty sides
// ----------------------------------------------------------------------------
module ihrc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/ihrc_front.sv =====
// ----------------------------------------------------------------------------
// ihrc_front
// takes header words, keeps the ones' complement sum and captures fields
// ----------------------------------------------------------------------------
module ihrc_front
  import ihrc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  input  in_word_t in_word,
  output logic     in_full,
  output logic     rec_push,
  output hdr_rec_t rec,
  input  logic     rec_full
);

  logic        in_hdr_r, in_hdr_nxt;
  logic [4:0]  count_r, count_nxt;
  logic [3:0]  ihl_r, ihl_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  ttl_r, ttl_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [31:0] src_r, src_nxt;
  logic [31:0] dst_r, dst_nxt;

  logic        accept, first, done;
  logic [15:0] w, sum0;
  logic [16:0] sum_wide;
  logic [4:0]  count0, header_words;
  logic [3:0]  ihl0;
  logic [7:0]  ttl0, proto0;
  logic [31:0] src0, dst0;

  assign in_full = rec_full;
  assign accept  = in_push && !in_full;
  assign first   = in_word.first_word;
  assign w       = in_word.header_word;

  always_comb begin
    if (first) begin
      ihl0   = w[11:8];
      count0 = '0;
      sum0   = '0;
      ttl0   = '0;
      proto0 = '0;
      src0   = '0;
      dst0   = '0;
    end else begin
      ihl0   = ihl_r;
      count0 = count_r;
      sum0   = sum_r;
      ttl0   = ttl_r;
      proto0 = proto_r;
      src0   = src_r;
      dst0   = dst_r;
    end
    header_words = {ihl0, 1'b0};

    ttl_nxt   = ttl0;
    proto_nxt = proto0;
    src_nxt   = src0;
    dst_nxt   = dst0;
    case (count0)
      POS_TTL_PROTO: begin
        ttl_nxt   = w[15:8];
        proto_nxt = w[7:0];
      end
      POS_SRC_HI: src_nxt[31:16] = w;
      POS_SRC_LO: src_nxt[15:0]  = w;
      POS_DST_HI: dst_nxt[31:16] = w;
      POS_DST_LO: dst_nxt[15:0]  = w;
      default: ;
    endcase

    sum_wide  = {1'b0, sum0} + {1'b0, w};
    sum_nxt   = sum_wide[15:0] + {15'd0, sum_wide[16]};
    count_nxt = count0 + 5'd1;
    ihl_nxt   = ihl0;

    rec_push   = 1'b0;
    done       = 1'b0;
    in_hdr_nxt = in_hdr_r;
    rec        = '{sum: sum_nxt, ihl: ihl0, ttl: ttl_nxt, protocol: proto_nxt,
                   src: src_nxt, dst: dst_nxt};

    if (accept && (first || in_hdr_r)) begin
      if (first && header_words == '0) begin
        done = 1'b1;
        rec  = '{sum: 16'd0, ihl: ihl0, ttl: 8'd0, protocol: 8'd0,
                 src: 32'd0, dst: 32'd0};
      end else begin
        done = (count_nxt == header_words);
      end
      rec_push   = done;
      in_hdr_nxt = !done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_hdr_r <= 1'b0;
      count_r  <= '0;
      ihl_r    <= '0;
      sum_r    <= '0;
    end else if (accept && (first || in_hdr_r)) begin
      in_hdr_r <= in_hdr_nxt;
      count_r  <= count_nxt;
      ihl_r    <= ihl_nxt;
      sum_r    <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (first || in_hdr_r)) begin
      ttl_r   <= ttl_nxt;
      proto_r <= proto_nxt;
      src_r   <= src_nxt;
      dst_r   <= dst_nxt;
    end
  end

endmodule

// ===== rtl/ihrc_back.sv =====
// ----------------------------------------------------------------------------
// ihrc_back
// holds the configuration and turns a finished header into a verdict
// ----------------------------------------------------------------------------
module ihrc_back
  import ihrc_pkg::*;
#(
  parameter int PROTOCOL_SLOTS = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   rec_empty,
  input  hdr_rec_t               rec,
  output logic                   rec_pop,
  output logic                   res_push,
  output out_word_t              res,
  input  logic                   res_full
);

  logic [31:0] local_addr_r;
  logic [3:0]  slot_en_r;
  logic [7:0]  slot_proto_r [PROTOCOL_SLOTS];

  logic        found;
  logic [1:0]  slot;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_addr_r <= '0;
      slot_en_r    <= '0;
      for (int i = 0; i < PROTOCOL_SLOTS; i++) begin
        slot_proto_r[i] <= '0;
      end
    end else if (cfg_valid) begin
      if (cfg_index == REG_LOCAL_ADDRESS) begin
        local_addr_r <= cfg_data;
      end
      if (cfg_index == REG_SLOT_ENABLE) begin
        slot_en_r <= cfg_data[3:0];
      end
      for (int i = 0; i < PROTOCOL_SLOTS; i++) begin
        if (cfg_index == REG_SLOT0_PROTO + CFG_INDEX_W'(i)) begin
          slot_proto_r[i] <= cfg_data[7:0];
        end
      end
    end
  end

  // lowest enabled matching slot wins
  always_comb begin
    found = 1'b0;
    slot  = '0;
    for (int i = PROTOCOL_SLOTS - 1; i >= 0; i--) begin
      if (slot_en_r[i] && slot_proto_r[i] == rec.protocol) begin
        found = 1'b1;
        slot  = 2'(i);
      end
    end
  end

  always_comb begin
    res.protocol       = rec.protocol;
    res.source_address = rec.src;
    res.matched_slot   = '0;
    if (rec.sum != 16'hFFFF) begin
      res.status = ST_CHECKSUM_BAD;
    end else if (rec.ihl != IHL_NO_OPTIONS) begin
      res.status = ST_OPTIONS;
    end else if (rec.ttl == '0) begin
      res.status = ST_TTL_ZERO;
    end else if (rec.dst != local_addr_r) begin
      res.status = ST_NOT_ADDRESSED;
    end else if (!found) begin
      res.status = ST_UNSUPPORTED;
    end else begin
      res.status       = ST_DELIVER;
      res.matched_slot = slot;
    end
  end

  assign rec_pop  = !rec_empty && !res_full;
  assign res_push = rec_pop;

endmodule

// ===== rtl/ipv4_header_receive_check.sv =====
// ----------------------------------------------------------------------------
// ipv4_header_receive_check
// checks received ipv4 headers and gives one verdict word per header
// ----------------------------------------------------------------------------
// Header words are taken at one word per clock while in_full is low, with no
// gaps needed, and a new header may start right behind the last one. Each word
// costs one end-around carry add in the front stage; a finished header is
// written to the middle queue and judged in the back stage, and its verdict word
// is written to the output queue once that queue has room. Up to two judged
// headers wait in the output queue and two more in the middle queue before
// in_full rises. Configuration writes are always ready and should only be
// issued while no header is open or waiting to be judged.
module ipv4_header_receive_check
  import ihrc_pkg::*;
#(
  parameter int PROTOCOL_SLOTS = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_push,
  input  in_word_t               in_word,
  output logic                   in_full,
  output logic                   out_empty,
  input  logic                   out_pop,
  output out_word_t              out_word,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  hdr_rec_t  front_rec, back_rec;
  logic      front_push, mid_full, mid_empty, mid_pop;
  out_word_t res;
  logic      res_push, res_full;

  ihrc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_word  (in_word),
    .in_full  (in_full),
    .rec_push (front_push),
    .rec      (front_rec),
    .rec_full (mid_full)
  );

  ihrc_fifo #(
    .WIDTH ($bits(hdr_rec_t)),
    .DEPTH (2)
  ) u_mid_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (front_push),
    .push_data (front_rec),
    .full      (mid_full),
    .pop       (mid_pop),
    .pop_data  (back_rec),
    .empty     (mid_empty)
  );

  ihrc_back #(
    .PROTOCOL_SLOTS (PROTOCOL_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rec_empty (mid_empty),
    .rec       (back_rec),
    .rec_pop   (mid_pop),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full)
  );

  ihrc_fifo #(
    .WIDTH ($bits(out_word_t)),
    .DEPTH (2)
  ) u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res),
    .full      (res_full),
    .pop       (out_pop),
    .pop_data  (out_word),
    .empty     (out_empty)
  );

endmodule
